// File: hw/rtl/watchpoint_slot_allocator_macros.svh
// ----------------------------------------------------------------------------
// Watchpoint slot allocator assertion macros
// Shared concurrent assertion wrappers; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef WATCHPOINT_SLOT_ALLOCATOR_MACROS_SVH
`define WATCHPOINT_SLOT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Generic form: explicit clock and reset
`define WSA_ASSERT_CR(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("watchpoint slot allocator assertion failed");

// Common form: block clock and reset
`define WSA_ASSERT(lbl, prop) `WSA_ASSERT_CR(lbl, clock, reset, prop)

`else

`define WSA_ASSERT_CR(lbl, clk, rst, prop)
`define WSA_ASSERT(lbl, prop)

`endif

`endif

// File: hw/rtl/wsa_pkg.sv
// ----------------------------------------------------------------------------
// Watchpoint slot allocator package
// Sizes, request and status codes, and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package wsa_pkg;

   localparam int SLOT_COUNT = 32;
   localparam int SLOT_W     = 6;
   localparam int RSP_SLOT_W = 5;
   localparam int STATUS_W   = 2;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POOL_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE  = 2'd2;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

   typedef struct packed {
      logic pool_empty;
      logic pool_full;
   } dp_sts_type;

endpackage

// File: hw/rtl/wsa_dpath.sv
// ----------------------------------------------------------------------------
// Watchpoint slot allocator datapath
// Free-list links, head, free count, in-use mask and response registers.
// ----------------------------------------------------------------------------
`include "watchpoint_slot_allocator_macros.svh"

module wsa_dpath
   import wsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   input  logic                  req_type,
   input  logic [SLOT_W-1:0]     req_slot_number,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [RSP_SLOT_W-1:0] rsp_slot_out
);

   logic                  type_ff;
   logic [SLOT_W-1:0]     slot_ff;

   logic [SLOT_W-1:0]     link_ff [SLOT_COUNT];
   logic [SLOT_W-1:0]     link_in [SLOT_COUNT];
   logic [SLOT_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SLOT_COUNT-1:0] mask_ff, mask_in;

   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [RSP_SLOT_W-1:0] slot_out_ff, slot_out_in;

   logic [IDX_W-1:0]      pop_idx;
   logic [IDX_W-1:0]      rel_idx;
   logic                  rel_ok;

   // A stale head past the pool maps to slot 0
   assign pop_idx = (int'(head_ff) < SLOT_COUNT) ? head_ff[IDX_W-1:0] : '0;
   assign rel_idx = slot_ff[IDX_W-1:0];
   assign rel_ok  = (int'(slot_ff) < SLOT_COUNT) && mask_ff[rel_idx];

   always_comb begin
      link_in     = link_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      mask_in     = mask_ff;
      status_in   = status_ff;
      slot_out_in = slot_out_ff;
      if (cmd.execute) begin
         status_in   = STATUS_OK;
         slot_out_in = '0;
         unique case (type_ff)
            REQ_ALLOC: begin
               if (count_ff == '0) begin
                  status_in = STATUS_POOL_EMPTY;
               end else begin
                  head_in          = link_ff[pop_idx];
                  count_in         = count_ff - CNT_W'(1);
                  mask_in[pop_idx] = 1'b1;
                  slot_out_in      = RSP_SLOT_W'(pop_idx);
               end
            end
            REQ_RELEASE: begin
               if (rel_ok) begin
                  mask_in[rel_idx] = 1'b0;
                  link_in[rel_idx] = head_ff;
                  head_in          = slot_ff;
                  count_in         = count_ff + CNT_W'(1);
                  slot_out_in      = RSP_SLOT_W'(slot_ff);
               end else begin
                  status_in = STATUS_NOT_IN_USE;
               end
            end
            default: begin
               status_in = STATUS_NOT_IN_USE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            link_ff[i] <= SLOT_W'(i + 1);
         end
         head_ff  <= '0;
         count_ff <= CNT_W'(SLOT_COUNT);
         mask_ff  <= '0;
      end else begin
         link_ff  <= link_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         mask_ff  <= mask_in;
      end
   end

   // Request capture and response hold need no reset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         slot_ff <= req_slot_number;
      end
      status_ff   <= status_in;
      slot_out_ff <= slot_out_in;
   end

   assign sts.pool_empty = (count_ff == '0);
   assign sts.pool_full  = (count_ff == CNT_W'(SLOT_COUNT));
   assign rsp_status     = status_ff;
   assign rsp_slot_out   = slot_out_ff;

   `WSA_ASSERT(a_count_matches_mask, (int'(count_ff) + $countones(mask_ff)) == SLOT_COUNT)
   `WSA_ASSERT(a_fail_zero_slot, (cmd.execute && type_ff == REQ_ALLOC && count_ff == '0) |=> (status_ff == STATUS_POOL_EMPTY && slot_out_ff == '0))
   `WSA_ASSERT(a_release_clears, (cmd.execute && type_ff == REQ_RELEASE && rel_ok) |=> (count_ff == $past(count_ff) + CNT_W'(1)))

endmodule

// File: hw/rtl/wsa_ctrl.sv
// ----------------------------------------------------------------------------
// Watchpoint slot allocator controller
// Sequences capture and execute, drives busy and the response strobe.
// ----------------------------------------------------------------------------
`include "watchpoint_slot_allocator_macros.svh"

module wsa_ctrl
   import wsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_strobe,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in    = state_ff;
      strobe_in   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            strobe_in   = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   `WSA_ASSERT(a_accept_executes, (start && !busy_ff) |=> (state_ff == ST_EXEC && busy_ff))
   `WSA_ASSERT(a_exec_strobes, (state_ff == ST_EXEC) |=> (strobe_ff && !busy_ff))
   `WSA_ASSERT(a_pool_only_on_exec, (state_ff != ST_EXEC) |=> $stable(sts))

endmodule

// File: hw/rtl/watchpoint_slot_allocator.sv
// ----------------------------------------------------------------------------
// Watchpoint slot allocator
// Pool of numbered slots handed out and taken back through a LIFO free list.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high while busy is low. Busy then
// stays high while the free-list link array, head, count and in-use mask
// are updated in ST_EXEC, and the result appears on rsp_status and
// rsp_slot_out with rsp_strobe high for exactly one cycle, registered at the
// end of ST_EXEC. The receiver has no way to stall: sample the result in
// the strobe cycle. Busy is already low in the strobe cycle, so a new request
// may be issued there; the block takes no new transaction until the last one
// has passed the capture in ST_IDLE and the free-list update in ST_EXEC.
// Allocation returns the most recently released slot first; after reset
// slots come out in ascending order from slot 0.
module watchpoint_slot_allocator
   import wsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_type,
   input  logic [SLOT_W-1:0]     req_slot_number,
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [RSP_SLOT_W-1:0] rsp_slot_out
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   wsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .sts        (sts)
   );

   wsa_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_slot_number (req_slot_number),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out)
   );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Watchpoint slot allocator testbench
// Drives allocate and release transactions through the start/busy port with
// random idle gaps, predicts each status and slot from a LIFO free-list model
// kept alongside, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module tb;
   import wsa_pkg::*;

   localparam int RUN_LIMIT   = 200000;
   localparam int ITEM_TARGET = 800;
   localparam int DRAIN_WAIT  = 8;

   typedef struct {
      logic              kind;
      logic [SLOT_W-1:0] num;
      int                gap;
   } slot_req_type;

   typedef struct {
      logic [STATUS_W-1:0]   status;
      logic [RSP_SLOT_W-1:0] slot;
   } grant_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_type = REQ_ALLOC;
   logic [SLOT_W-1:0]     req_slot_number = '0;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [RSP_SLOT_W-1:0] rsp_slot_out;

   slot_req_type pending_reqs[$];
   grant_type    expected_grants[$];
   int           total_items = 0;
   int           accepted_count = 0;
   int           failures = 0;
   int           cycle_count = 0;

   // free-list shadow
   logic [SLOT_W-1:0] free_next[0:63];
   logic [SLOT_W-1:0] free_head;
   int                free_total;
   logic [63:0]       in_use;

   watchpoint_slot_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_slot_number (req_slot_number),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic reset_pool();
      for (int i = 0; i < 64; i++) begin
         free_next[i] = SLOT_W'((i + 1) & 63);
      end
      free_head  = '0;
      free_total = SLOT_COUNT;
      in_use     = '0;
   endtask

   function automatic grant_type apply_request(logic kind, logic [SLOT_W-1:0] num);
      grant_type         g;
      logic [SLOT_W-1:0] s;
      g.status = STATUS_OK;
      g.slot   = '0;
      if (kind == REQ_ALLOC) begin
         if (free_total == 0) begin
            g.status = STATUS_POOL_EMPTY;
         end else begin
            s = (free_head >= SLOT_COUNT) ? '0 : free_head;
            free_head = free_next[s];
            free_total--;
            in_use[s] = 1'b1;
            g.slot = s[RSP_SLOT_W-1:0];
         end
      end else if (num < SLOT_COUNT && in_use[num]) begin
         in_use[num]    = 1'b0;
         free_next[num] = free_head;
         free_head      = num;
         free_total++;
         g.slot = num[RSP_SLOT_W-1:0];
      end else begin
         g.status = STATUS_NOT_IN_USE;
      end
      return g;
   endfunction

   function automatic int pick_gap(bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SLOT_W-1:0] pick_release_num();
      if ($urandom_range(0, 99) < 85) return SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
      return SLOT_W'($urandom_range(SLOT_COUNT, 63));
   endfunction

   task automatic add_req(logic kind, logic [SLOT_W-1:0] num, bit burst);
      slot_req_type item;
      item.kind = kind;
      item.num  = num;
      item.gap  = pick_gap(burst);
      pending_reqs.push_back(item);
      total_items++;
   endtask

   // driver: present one transaction at a time, hold it while busy
   always @(posedge clock) begin : driver
      slot_req_type item;
      int           idle_left;
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
         reset_pool();
      end else begin
         if (start && !busy) begin
            expected_grants.push_back(apply_request(req_type, req_slot_number));
            accepted_count++;
         end
         if (start && busy) begin
            // hold the current transaction
         end else if (idle_left > 0) begin
            start <= 1'b0;
            idle_left--;
         end else if (pending_reqs.size() > 0) begin
            item = pending_reqs.pop_front();
            start           <= 1'b1;
            req_type        <= item.kind;
            req_slot_number <= item.num;
            idle_left = item.gap;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results come without back-pressure, take each strobe
   always @(posedge clock) begin : monitor
      grant_type exp;
      if (!reset && rsp_strobe) begin
         if (expected_grants.size() == 0) begin
            $error("unexpected result: rsp_status %0d, rsp_slot_out %0d",
                   rsp_status, rsp_slot_out);
            failures++;
         end else begin
            exp = expected_grants.pop_front();
            if (rsp_status !== exp.status) begin
               $error("rsp_status mismatch: expected %0d, actual %0d",
                      exp.status, rsp_status);
               failures++;
            end
            if (rsp_slot_out !== exp.slot) begin
               $error("rsp_slot_out mismatch: expected %0d, actual %0d",
                      exp.slot, rsp_slot_out);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      logic [SLOT_W-1:0] order[0:63];
      logic [SLOT_W-1:0] tmp;
      int                mode;
      int                alloc_pct;
      int                j;
      bit                burst;

      // directed: releases of free and out-of-range slots, LIFO reuse
      add_req(REQ_RELEASE, 6'd0, 1'b0);
      add_req(REQ_RELEASE, 6'd63, 1'b0);
      add_req(REQ_RELEASE, SLOT_W'(SLOT_COUNT), 1'b0);
      add_req(REQ_RELEASE, SLOT_W'(SLOT_COUNT - 1), 1'b1);
      add_req(REQ_ALLOC, 6'd63, 1'b1);
      add_req(REQ_ALLOC, 6'd0, 1'b1);
      add_req(REQ_ALLOC, 6'd42, 1'b0);
      add_req(REQ_ALLOC, 6'd21, 1'b0);
      add_req(REQ_RELEASE, 6'd2, 1'b1);
      add_req(REQ_RELEASE, 6'd2, 1'b1);
      add_req(REQ_ALLOC, 6'd0, 1'b1);
      add_req(REQ_RELEASE, 6'd0, 1'b0);
      add_req(REQ_RELEASE, 6'd3, 1'b0);
      add_req(REQ_ALLOC, 6'd0, 1'b1);
      add_req(REQ_ALLOC, 6'd0, 1'b1);
      add_req(REQ_ALLOC, 6'd0, 1'b0);
      add_req(REQ_RELEASE, 6'd45, 1'b0);
      add_req(REQ_RELEASE, 6'd4, 1'b0);
      add_req(REQ_RELEASE, 6'd1, 1'b0);

      // random: blocks biased toward filling, draining, a balanced mix, or full cycles
      while (total_items < ITEM_TARGET) begin
         mode  = $urandom_range(0, 3);
         burst = ($urandom_range(0, 3) == 0);
         if (mode == 3) begin
            // exhaust the pool, then free every slot in shuffled order
            for (int i = 0; i < SLOT_COUNT + 2; i++) begin
               add_req(REQ_ALLOC, SLOT_W'($urandom_range(0, 63)), burst);
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
               order[i] = SLOT_W'(i);
            end
            for (int i = SLOT_COUNT - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
               add_req(REQ_RELEASE, order[i], burst);
            end
         end else begin
            alloc_pct = (mode == 0) ? 90 : (mode == 1) ? 15 : 50;
            for (int i = 0; i < 40; i++) begin
               if ($urandom_range(0, 99) < alloc_pct) begin
                  add_req(REQ_ALLOC, SLOT_W'($urandom_range(0, 63)), burst);
               end else begin
                  add_req(REQ_RELEASE, pick_release_num(), burst);
               end
            end
         end
      end

      while (accepted_count < total_items) @(posedge clock);
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
